// File: rtl/core/dnd_pkg.sv
// shared constants, status codes and controller/datapath interface types
`timescale 1ns / 1ps

package dnd_pkg;

    localparam int PACKET_DEPTH = 512;
    localparam int NAME_DEPTH   = 256;

    localparam int ADDR_W   = 9;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 9;
    localparam int POS_W    = 15;
    localparam int PTR_HI_W = 6;
    localparam int EPOCH_W  = 8;

    localparam logic [BYTE_W-1:0] PTR_TAG = 8'hC0;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_DECODE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LOOP     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic    clr_step;
        logic    load_write;
        logic    rd_start;
        logic    dec_start;
        logic    fetch;
        logic    take_zero;
        logic    take_ptr;
        logic    take_len;
        logic    ptr_jump;
        logic    copy_read;
        logic    copy_write;
        logic    set_status;
        status_t code;
        logic    out_dec;
        logic    out_rd;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic pos_oob;
        logic pos1_oob;
        logic byte_zero;
        logic byte_ptr;
        logic visited;
        logic cnt_full;
        logic rem_zero;
        logic out_free;
        logic epoch_max;
    } stat_t;

endpackage

// File: rtl/core/dnd_ram.sv
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/dnd_ctrl.sv
// controller state machine for the label walk, reads and visited-map sweeps
`timescale 1ns / 1ps

module dnd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    mode,
    input  dnd_pkg::stat_t stat,
    output dnd_pkg::cmd_t  cmd,
    output logic          in_stall
);

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_RD_WAIT = 9'b000000100,
        S_FETCH   = 9'b000001000,
        S_EXAM    = 9'b000010000,
        S_PTR     = 9'b000100000,
        S_LABEL   = 9'b001000000,
        S_COPY    = 9'b010000000,
        S_FINISH  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.code   = dnd_pkg::ST_OK;
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (mode)
                        dnd_pkg::MODE_LOAD:
                        begin
                            cmd.load_write = 1'b1;
                        end
                        dnd_pkg::MODE_DECODE:
                        begin
                            cmd.dec_start = 1'b1;
                            state_next    = S_FETCH;
                        end
                        dnd_pkg::MODE_READ:
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_RD_WAIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_rd = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                if (stat.pos_oob)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = dnd_pkg::ST_RANGE;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_EXAM;
                end
            end
            S_EXAM:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_FINISH;
                if (stat.byte_zero)
                begin
                    if (stat.cnt_full)
                    begin
                        cmd.code = dnd_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.take_zero = 1'b1;
                        cmd.code      = dnd_pkg::ST_OK;
                    end
                end
                else if (stat.byte_ptr)
                begin
                    if (stat.visited)
                    begin
                        cmd.code = dnd_pkg::ST_LOOP;
                    end
                    else if (stat.pos1_oob)
                    begin
                        cmd.code = dnd_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cmd.set_status = 1'b0;
                        cmd.take_ptr   = 1'b1;
                        state_next     = S_PTR;
                    end
                end
                else if (stat.cnt_full)
                begin
                    cmd.code = dnd_pkg::ST_OVERFLOW;
                end
                else
                begin
                    cmd.set_status = 1'b0;
                    cmd.take_len   = 1'b1;
                    state_next     = S_LABEL;
                end
            end
            S_PTR:
            begin
                cmd.ptr_jump = 1'b1;
                state_next   = S_FETCH;
            end
            S_LABEL:
            begin
                if (stat.rem_zero)
                begin
                    state_next = S_FETCH;
                end
                else if (stat.pos_oob)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = dnd_pkg::ST_RANGE;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.copy_read = 1'b1;
                    state_next    = S_COPY;
                end
            end
            S_COPY:
            begin
                if (stat.cnt_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = dnd_pkg::ST_OVERFLOW;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.copy_write = 1'b1;
                    state_next     = S_LABEL;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_dec = 1'b1;
                    state_next  = stat.epoch_max ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/core/dnd_datapath.sv
// datapath: packet, name and visited memories, walk registers and result register
`timescale 1ns / 1ps

module dnd_datapath #(
    parameter int PACKET_DEPTH = dnd_pkg::PACKET_DEPTH,
    parameter int NAME_DEPTH   = dnd_pkg::NAME_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dnd_pkg::cmd_t               cmd,
    output dnd_pkg::stat_t              stat,
    input  logic [dnd_pkg::ADDR_W-1:0]  addr,
    input  logic [dnd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic                        kind,
    output logic [1:0]                  status,
    output logic [dnd_pkg::ADDR_W-1:0]  wire_span,
    output logic [dnd_pkg::LEN_W-1:0]   name_length,
    output logic [dnd_pkg::BYTE_W-1:0]  name_byte
);

    localparam int PAW    = $clog2(PACKET_DEPTH);
    localparam int NAW    = $clog2(NAME_DEPTH);
    localparam int CW     = $clog2(NAME_DEPTH + 1);
    localparam int CMPW   = (CW > dnd_pkg::ADDR_W) ? CW : dnd_pkg::ADDR_W;
    localparam int POS_W  = dnd_pkg::POS_W;
    localparam int ADDR_W = dnd_pkg::ADDR_W;
    localparam int BYTE_W = dnd_pkg::BYTE_W;
    localparam int LEN_W  = dnd_pkg::LEN_W;
    localparam int EW     = dnd_pkg::EPOCH_W;

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [BYTE_W-1:0]         rem_reg, rem_next;
    logic                      jumped_reg, jumped_next;
    logic [ADDR_W-1:0]         wire_reg, wire_next;
    logic [ADDR_W-1:0]         start_reg, start_next;
    logic [dnd_pkg::PTR_HI_W-1:0] hi_reg, hi_next;
    dnd_pkg::status_t          status_reg, status_next;
    logic                      rd_hit_reg;

    logic [CW-1:0]             name_count_reg;
    logic [PAW-1:0]            clr_cnt_reg;
    logic [EW-1:0]             epoch_reg;
    logic                      out_valid_reg;

    logic                      out_kind_reg;
    dnd_pkg::status_t          out_status_reg;
    logic [ADDR_W-1:0]         out_wire_reg;
    logic [LEN_W-1:0]          out_len_reg;
    logic [BYTE_W-1:0]         out_byte_reg;

    logic [BYTE_W-1:0]         pkt_rdata;
    logic [BYTE_W-1:0]         name_rdata;
    logic [EW-1:0]             vis_rdata;

    logic [POS_W-1:0]          pos_plus1;
    logic [POS_W-1:0]          load_pos;
    logic                      load_in_range;
    logic [ADDR_W-1:0]         wire_from_pos;
    logic [CMPW-1:0]           addr_ext;
    logic                      dec_ok;
    logic [CW-1:0]             res_cnt;
    logic [ADDR_W-1:0]         res_wire;
    logic [CMPW-1:0]           res_cnt_ext;
    logic [CMPW-1:0]           count_ext;
    logic                      out_free;

    assign pos_plus1     = pos_reg + POS_W'(1);
    assign load_pos      = POS_W'(addr);
    assign load_in_range = load_pos < POS_W'(PACKET_DEPTH);
    assign wire_from_pos = pos_reg[ADDR_W-1:0] - start_reg;
    assign addr_ext      = CMPW'(addr);
    assign dec_ok        = (status_reg == dnd_pkg::ST_OK);
    assign res_cnt       = dec_ok ? cnt_reg : '0;
    assign res_wire      = dec_ok ? wire_reg : '0;
    assign res_cnt_ext   = CMPW'(res_cnt);
    assign count_ext     = CMPW'(name_count_reg);
    assign out_free      = !out_valid_reg || !out_stall;

    // memories
    dnd_ram #(.WIDTH(BYTE_W), .DEPTH(PACKET_DEPTH)) u_pkt_ram (
        .clk   (clk),
        .we    (cmd.load_write && load_in_range),
        .waddr (load_pos[PAW-1:0]),
        .wdata (data_byte),
        .re    (cmd.fetch || cmd.take_ptr || cmd.copy_read),
        .raddr (cmd.take_ptr ? pos_plus1[PAW-1:0] : pos_reg[PAW-1:0]),
        .rdata (pkt_rdata)
    );

    dnd_ram #(.WIDTH(BYTE_W), .DEPTH(NAME_DEPTH)) u_name_ram (
        .clk   (clk),
        .we    (cmd.take_zero || cmd.take_len || cmd.copy_write),
        .waddr (cnt_reg[NAW-1:0]),
        .wdata (pkt_rdata),
        .re    (cmd.rd_start),
        .raddr (addr_ext[NAW-1:0]),
        .rdata (name_rdata)
    );

    // visited map holds the epoch of the decode that followed each pointer
    dnd_ram #(.WIDTH(EW), .DEPTH(PACKET_DEPTH)) u_vis_ram (
        .clk   (clk),
        .we    (cmd.clr_step || cmd.take_ptr),
        .waddr (cmd.clr_step ? clr_cnt_reg : pos_reg[PAW-1:0]),
        .wdata (cmd.clr_step ? EW'(0) : epoch_reg),
        .re    (cmd.fetch),
        .raddr (pos_reg[PAW-1:0]),
        .rdata (vis_rdata)
    );

    always_comb
    begin
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        jumped_next = jumped_reg;
        wire_next   = wire_reg;
        start_next  = start_reg;
        hi_next     = hi_reg;
        status_next = status_reg;
        if (cmd.dec_start)
        begin
            start_next  = addr;
            pos_next    = load_pos;
            cnt_next    = '0;
            jumped_next = 1'b0;
            wire_next   = '0;
        end
        if (cmd.take_zero)
        begin
            if (!jumped_reg)
            begin
                wire_next = wire_from_pos + ADDR_W'(1);
            end
            cnt_next = cnt_reg + CW'(1);
        end
        if (cmd.take_ptr)
        begin
            if (!jumped_reg)
            begin
                wire_next   = wire_from_pos + ADDR_W'(2);
                jumped_next = 1'b1;
            end
            hi_next = pkt_rdata[dnd_pkg::PTR_HI_W-1:0];
        end
        if (cmd.take_len)
        begin
            cnt_next = cnt_reg + CW'(1);
            pos_next = pos_plus1;
            rem_next = pkt_rdata;
        end
        if (cmd.ptr_jump)
        begin
            pos_next = POS_W'({hi_reg, pkt_rdata});
        end
        if (cmd.copy_write)
        begin
            cnt_next = cnt_reg + CW'(1);
            pos_next = pos_plus1;
            rem_next = rem_reg - BYTE_W'(1);
        end
        if (cmd.set_status)
        begin
            status_next = cmd.code;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        jumped_reg <= jumped_next;
        wire_reg   <= wire_next;
        start_reg  <= start_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
        if (cmd.rd_start)
        begin
            rd_hit_reg <= (addr_ext < count_ext) && (addr_ext < CMPW'(NAME_DEPTH));
        end
        if (cmd.out_dec)
        begin
            out_kind_reg   <= dnd_pkg::KIND_DECODE;
            out_status_reg <= status_reg;
            out_wire_reg   <= res_wire;
            out_len_reg    <= res_cnt_ext[LEN_W-1:0];
            out_byte_reg   <= '0;
        end
        else if (cmd.out_rd)
        begin
            out_kind_reg   <= dnd_pkg::KIND_READ;
            out_status_reg <= dnd_pkg::ST_OK;
            out_wire_reg   <= '0;
            out_len_reg    <= count_ext[LEN_W-1:0];
            out_byte_reg   <= rd_hit_reg ? name_rdata : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_count_reg <= '0;
            clr_cnt_reg    <= '0;
            epoch_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                if (stat.clr_last)
                begin
                    clr_cnt_reg <= '0;
                    epoch_reg   <= EW'(1);
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + PAW'(1);
                end
            end
            if (cmd.out_dec)
            begin
                name_count_reg <= res_cnt;
                if (!stat.epoch_max)
                begin
                    epoch_reg <= epoch_reg + EW'(1);
                end
            end
            if (cmd.out_dec || cmd.out_rd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clr_last  = (clr_cnt_reg == PAW'(PACKET_DEPTH - 1));
    assign stat.pos_oob   = (pos_reg >= POS_W'(PACKET_DEPTH));
    assign stat.pos1_oob  = (pos_plus1 >= POS_W'(PACKET_DEPTH));
    assign stat.byte_zero = (pkt_rdata == '0);
    assign stat.byte_ptr  = ((pkt_rdata & dnd_pkg::PTR_TAG) == dnd_pkg::PTR_TAG);
    assign stat.visited   = (vis_rdata == epoch_reg);
    assign stat.cnt_full  = (cnt_reg >= CW'(NAME_DEPTH));
    assign stat.rem_zero  = (rem_reg == '0);
    assign stat.out_free  = out_free;
    assign stat.epoch_max = &epoch_reg;

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign status      = out_status_reg;
    assign wire_span   = out_wire_reg;
    assign name_length = out_len_reg;
    assign name_byte   = out_byte_reg;

endmodule

// File: rtl/core/dns_name_decompressor.sv
// top level of the dns name decompressor
`timescale 1ns / 1ps

// Loads packet bytes one per cycle (mode 0) while in_stall is low, expands the
// wire-format name at a start offset (mode 1) and returns name bytes (mode 2).
// A load gives no result; a read waits for the output register to be free and
// stalls the input until its result is in it. A decode walks the packet
// through the single read port of the packet memory, whose read data is
// registered: each byte is fetched and examined, a pointer has its second byte
// read before the jump, and each label byte is read and then written to the
// name memory; the input stalls until the summary result is in the output
// register. Loops are caught with an epoch-tagged visited memory; after reset,
// and after every 255th decode, it is swept clear while the input stalls. A
// result waits in the output register while out_stall is high.
module dns_name_decompressor #(
    parameter int PACKET_DEPTH = dnd_pkg::PACKET_DEPTH,
    parameter int NAME_DEPTH   = dnd_pkg::NAME_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [dnd_pkg::ADDR_W-1:0]  addr,
    input  logic [dnd_pkg::BYTE_W-1:0]  data_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [1:0]                  status,
    output logic [dnd_pkg::ADDR_W-1:0]  wire_span,
    output logic [dnd_pkg::LEN_W-1:0]   name_length,
    output logic [dnd_pkg::BYTE_W-1:0]  name_byte
);

    dnd_pkg::cmd_t  cmd;
    dnd_pkg::stat_t stat;

    dnd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    dnd_datapath #(
        .PACKET_DEPTH (PACKET_DEPTH),
        .NAME_DEPTH   (NAME_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .addr        (addr),
        .data_byte   (data_byte),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .kind        (kind),
        .status      (status),
        .wire_span   (wire_span),
        .name_length (name_length),
        .name_byte   (name_byte)
    );

endmodule

// File: rtl/core/dnd_checker.sv
// port-level assertions for the dns name decompressor and their bind
`timescale 1ns / 1ps

module dnd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  mode,
    input logic [dnd_pkg::ADDR_W-1:0]  addr,
    input logic [dnd_pkg::BYTE_W-1:0]  data_byte,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        kind,
    input logic [1:0]                  status,
    input logic [dnd_pkg::ADDR_W-1:0]  wire_span,
    input logic [dnd_pkg::LEN_W-1:0]   name_length,
    input logic [dnd_pkg::BYTE_W-1:0]  name_byte
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(addr)
            && $stable(data_byte))
        else $error("stalled input changed");

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(status)
            && $stable(wire_span) && $stable(name_length) && $stable(name_byte))
        else $error("stalled result changed");

    // failed decode reports no lengths
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == dnd_pkg::KIND_DECODE && status != dnd_pkg::ST_OK
            |-> wire_span == '0 && name_length == '0)
        else $error("failed decode with nonzero lengths");

    // decode summary carries no name byte
    a_dec_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == dnd_pkg::KIND_DECODE |-> name_byte == '0)
        else $error("decode result with name byte");

    // read result carries ok status and no wire length
    a_rd_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == dnd_pkg::KIND_READ
            |-> status == dnd_pkg::ST_OK && wire_span == '0)
        else $error("read result with status or wire length");

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (.*);
